// ===== rtl/sprite_animation_sequencer_unit_macros.svh =====
// Assertion macros shared by the sprite animation sequencer RTL.
`ifndef SPRITE_ANIMATION_SEQUENCER_UNIT_MACROS_SVH
`define SPRITE_ANIMATION_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SAS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sas_pkg.sv =====
// Types and constants of the sprite animation sequencer.
`timescale 1ns / 1ps
package sas_pkg;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_PLAY   = 2'd1,
        MODE_QUEUE  = 2'd2,
        MODE_DEFINE = 2'd3
    } t_mode;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_QUEUE_FULL = 2'd1;
    localparam logic [1:0] STATUS_UNDEFINED  = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEET_COLUMNS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd3;

    localparam int ID_W   = 4;
    localparam int LOOP_W = 16;
    localparam int POS_W  = 22;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LOOP_W-1:0] loops;
    } t_q_entry;

    typedef struct packed {
        logic [10:0] cols;
        logic [12:0] width;
        logic [12:0] height;
    } t_geom;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_QRD,
        S_QSEL,
        S_BRD,
        S_BSEL,
        S_PSTART,
        S_PWAIT,
        S_DONE
    } t_state;

endpackage

// ===== rtl/sprite_animation_sequencer_unit.sv =====
// Sprite animation sequencer top level: command sequencer, state registers and output register.
`timescale 1ns / 1ps
// Each request (tick, play, queue or define) yields exactly one result holding the
// current frame and its pixel position in the sheet. Requests are taken one at a
// time. A tick that wraps the animation and switches to the head of the play queue
// passes through further states, since that head entry and then its bounds are read
// again from the registered memories. The divider that splits the frame into sheet
// row and column works one quotient bit per cycle. A finished result waits in the
// output register while the next request is accepted. Configuration writes are
// always taken and belong in idle time.
module sprite_animation_sequencer_unit #(
    parameter int NUM_ANIMS   = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int FRAME_BITS  = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_mode,
    input  logic [sas_pkg::ID_W-1:0]          i_anim_id,
    input  logic [sas_pkg::LOOP_W-1:0]        i_loop_count,
    input  logic [9:0]                        i_first_frame,
    input  logic [9:0]                        i_last_frame,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [9:0]                        o_frame_index,
    output logic [sas_pkg::POS_W-1:0]         o_source_x,
    output logic [sas_pkg::POS_W-1:0]         o_source_y,
    output logic                              o_frame_advanced,
    output logic [1:0]                        o_status,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sas_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);
    import sas_pkg::*;
`include "sprite_animation_sequencer_unit_macros.svh"

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    // configuration
    logic [15:0] r_period;
    t_geom       r_geom;

    // sequencer and animation state
    t_state              r_state,   n_state;
    t_mode               r_mode,    n_mode;
    logic [ID_W-1:0]     r_id,      n_id;
    logic [LOOP_W-1:0]   r_loops,   n_loops;
    logic [9:0]          r_first,   n_first;
    logic [9:0]          r_last,    n_last;
    logic [QW-1:0]       r_head,    n_head;
    logic [CW-1:0]       r_count,   n_count;
    logic [ID_W-1:0]     r_cur,     n_cur;
    logic [FRAME_BITS-1:0] r_frame, n_frame;
    logic [15:0]         r_elapsed, n_elapsed;
    logic                r_adv,     n_adv;
    logic [1:0]          r_status,  n_status;

    // output register
    logic                r_ovalid,  n_ovalid;
    logic [9:0]          r_oframe,  n_oframe;
    logic [POS_W-1:0]    r_ox,      n_ox;
    logic [POS_W-1:0]    r_oy,      n_oy;
    logic                r_oadv,    n_oadv;
    logic [1:0]          r_ostat,   n_ostat;

    // memory and unit connections
    logic [ID_W-1:0]       a_rd_id;
    logic                  a_we;
    logic [FRAME_BITS-1:0] a_first;
    logic [FRAME_BITS-1:0] a_last;
    logic                  a_def;
    logic                  q_we;
    logic [QW-1:0]         q_waddr;
    t_q_entry              q_wdata;
    t_q_entry              q_rd;
    logic                  pos_start;
    logic                  pos_done;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;

    logic [SW-1:0]         tail_sum;
    logic [QW-1:0]         tail_slot;
    logic [SW-1:0]         head_sum;
    logic [QW-1:0]         head_inc;
    logic [15:0]           el_inc;
    logic [FRAME_BITS:0]   frame_next;
    logic                  pop;

    assign tail_sum   = SW'(r_head) + SW'(r_count);
    assign tail_slot  = QW'((tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum);
    assign head_sum   = SW'(r_head) + SW'(1);
    assign head_inc   = (head_sum == DEPTH_S) ? '0 : QW'(head_sum);
    assign el_inc     = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign frame_next = {1'b0, r_frame} + (FRAME_BITS + 1)'(1);
    assign pop        = q_rd.loops == LOOP_W'(1);

    // Look up the play target on accept, the current animation otherwise.
    assign a_rd_id = (r_state == S_IDLE && t_mode'(i_mode) == MODE_PLAY) ? i_anim_id : r_cur;

    sas_anim_tbl #(
        .NUM_ANIMS  (NUM_ANIMS),
        .FRAME_BITS (FRAME_BITS)
    ) u_anim_tbl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_id    (a_rd_id),
        .i_wr_en    (a_we),
        .i_wr_id    (r_id),
        .i_wr_first (FRAME_BITS'(r_first)),
        .i_wr_last  (FRAME_BITS'(r_last)),
        .o_first    (a_first),
        .o_last     (a_last),
        .o_defined  (a_def)
    );

    sas_queue_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (r_head),
        .o_rdata (q_rd)
    );

    sas_pos_unit #(
        .FRAME_BITS (FRAME_BITS)
    ) u_pos_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pos_start),
        .i_frame (r_frame),
        .i_geom  (r_geom),
        .o_done  (pos_done),
        .o_x     (pos_x),
        .o_y     (pos_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 16'd100;
            r_geom   <= '{cols: 11'd1, width: 13'd16, height: 13'd16};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_PERIOD:  r_period      <= i_cfg_data;
                CFG_SHEET_COLUMNS: r_geom.cols   <= i_cfg_data[10:0];
                CFG_FRAME_WIDTH:   r_geom.width  <= i_cfg_data[12:0];
                CFG_FRAME_HEIGHT:  r_geom.height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_cur     <= '0;
            r_frame   <= '0;
            r_elapsed <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_cur     <= n_cur;
            r_frame   <= n_frame;
            r_elapsed <= n_elapsed;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_id     <= n_id;
        r_loops  <= n_loops;
        r_first  <= n_first;
        r_last   <= n_last;
        r_adv    <= n_adv;
        r_status <= n_status;
        r_oframe <= n_oframe;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_oadv   <= n_oadv;
        r_ostat  <= n_ostat;
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_id      = r_id;
        n_loops   = r_loops;
        n_first   = r_first;
        n_last    = r_last;
        n_head    = r_head;
        n_count   = r_count;
        n_cur     = r_cur;
        n_frame   = r_frame;
        n_elapsed = r_elapsed;
        n_adv     = r_adv;
        n_status  = r_status;
        n_ovalid  = r_ovalid;
        n_oframe  = r_oframe;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_oadv    = r_oadv;
        n_ostat   = r_ostat;
        a_we      = 1'b0;
        q_we      = 1'b0;
        q_waddr   = tail_slot;
        q_wdata   = '{id: r_id, loops: r_loops};
        pos_start = 1'b0;

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode  = t_mode'(i_mode);
                    n_id    = i_anim_id;
                    n_loops = i_loop_count;
                    n_first = i_first_frame;
                    n_last  = i_last_frame;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_adv    = 1'b0;
                n_status = STATUS_OK;
                n_state  = S_PSTART;
                unique case (r_mode)
                    MODE_TICK: begin
                        if (el_inc >= r_period) begin
                            n_elapsed = '0;
                            n_adv     = 1'b1;
                            if (frame_next <= {1'b0, a_last}) begin
                                n_frame = frame_next[FRAME_BITS-1:0];
                            end else if (r_count == '0) begin
                                n_frame = a_first;
                            end else begin
                                // use up one loop of the head; zero loops is endless
                                if (q_rd.loops != '0) begin
                                    q_we    = 1'b1;
                                    q_waddr = r_head;
                                    q_wdata = '{id: q_rd.id, loops: q_rd.loops - LOOP_W'(1)};
                                    if (pop) begin
                                        n_head  = head_inc;
                                        n_count = r_count - CW'(1);
                                    end
                                end
                                if (q_rd.loops != '0 && pop && r_count == CW'(1)) begin
                                    n_frame = a_first;
                                end else begin
                                    n_state = S_QRD;
                                end
                            end
                        end else begin
                            n_elapsed = el_inc;
                        end
                    end
                    MODE_PLAY: begin
                        if (a_def) begin
                            n_head    = '0;
                            n_count   = CW'(1);
                            q_we      = 1'b1;
                            q_waddr   = '0;
                            n_cur     = r_id;
                            n_frame   = a_first;
                            n_elapsed = '0;
                            n_adv     = 1'b1;
                        end else begin
                            n_status = STATUS_UNDEFINED;
                        end
                    end
                    MODE_QUEUE: begin
                        if (r_count >= DEPTH_C) begin
                            n_status = STATUS_QUEUE_FULL;
                        end else begin
                            q_we    = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    MODE_DEFINE: begin
                        a_we = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_QRD: begin
                n_state = S_QSEL;
            end
            S_QSEL: begin
                n_cur   = q_rd.id;
                n_state = S_BRD;
            end
            S_BRD: begin
                n_state = S_BSEL;
            end
            S_BSEL: begin
                n_frame = a_first;
                n_state = S_PSTART;
            end
            S_PSTART: begin
                pos_start = 1'b1;
                n_state   = S_PWAIT;
            end
            S_PWAIT: begin
                if (pos_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_oframe = 10'(r_frame);
                    n_ox     = pos_x;
                    n_oy     = pos_y;
                    n_oadv   = r_adv;
                    n_ostat  = r_status;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ready          = r_state == S_IDLE;
    assign o_valid          = r_ovalid;
    assign o_frame_index    = r_oframe;
    assign o_source_x       = r_ox;
    assign o_source_y       = r_oy;
    assign o_frame_advanced = r_oadv;
    assign o_status         = r_ostat;
    assign o_cfg_ready      = 1'b1;

    `SAS_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= DEPTH_C, "queue count beyond depth")
    `SAS_ASSERT_NEXT(a_accept_look, i_valid && o_ready, r_state == S_LOOK, "request not looked up")
    `SAS_ASSERT_IMPL(a_out_from_done, $rose(o_valid), $past(r_state == S_DONE), "stray result")
    `SAS_ASSERT_NEXT(a_start_wait, pos_start, r_state == S_PWAIT && !pos_done, "position unit race")

endmodule

// ===== rtl/sas_anim_tbl.sv =====
// Animation bounds memory with per-entry defined bits.
`timescale 1ns / 1ps
module sas_anim_tbl #(
    parameter int NUM_ANIMS  = 16,
    parameter int FRAME_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sas_pkg::ID_W-1:0]      i_rd_id,
    input  logic                          i_wr_en,
    input  logic [sas_pkg::ID_W-1:0]      i_wr_id,
    input  logic [FRAME_BITS-1:0]         i_wr_first,
    input  logic [FRAME_BITS-1:0]         i_wr_last,
    output logic [FRAME_BITS-1:0]         o_first,
    output logic [FRAME_BITS-1:0]         o_last,
    output logic                          o_defined
);
    import sas_pkg::*;

    localparam int AW = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
    localparam logic [8:0] NUM_LIM = 9'(NUM_ANIMS);

    logic [2*FRAME_BITS-1:0] mem [NUM_ANIMS];
    logic [2*FRAME_BITS-1:0] r_rdata;
    logic [NUM_ANIMS-1:0]    r_defined;
    logic                    r_ok;

    logic [AW+ID_W-1:0] rd_wide;
    logic [AW+ID_W-1:0] wr_wide;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               rd_in;
    logic               wr_in;

    assign rd_wide = {{AW{1'b0}}, i_rd_id};
    assign wr_wide = {{AW{1'b0}}, i_wr_id};
    assign rd_addr = rd_wide[AW-1:0];
    assign wr_addr = wr_wide[AW-1:0];
    assign rd_in   = {5'b0, i_rd_id} < NUM_LIM;
    assign wr_in   = {5'b0, i_wr_id} < NUM_LIM;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_in) begin
            mem[wr_addr] <= {i_wr_first, i_wr_last};
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_defined <= '0;
            r_ok      <= 1'b0;
        end else begin
            if (i_wr_en && wr_in) begin
                r_defined[wr_addr] <= 1'b1;
            end
            r_ok <= rd_in && r_defined[rd_addr];
        end
    end

    // An entry never defined reads as zero bounds.
    assign o_first   = r_ok ? r_rdata[2*FRAME_BITS-1:FRAME_BITS] : '0;
    assign o_last    = r_ok ? r_rdata[FRAME_BITS-1:0] : '0;
    assign o_defined = r_ok;

endmodule

// ===== rtl/sas_queue_ram.sv =====
// Play queue storage: one write port, one registered read port.
`timescale 1ns / 1ps
module sas_queue_ram #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] i_waddr,
    input  sas_pkg::t_q_entry     i_wdata,
    input  logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] i_raddr,
    output sas_pkg::t_q_entry     o_rdata
);
    import sas_pkg::*;

    t_q_entry mem [QUEUE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== rtl/sas_pos_unit.sv =====
// Sheet position: serial divide of the frame by the columns, then two multiplies.
`timescale 1ns / 1ps
module sas_pos_unit #(
    parameter int FRAME_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [FRAME_BITS-1:0]         i_frame,
    input  sas_pkg::t_geom                i_geom,
    output logic                          o_done,
    output logic [sas_pkg::POS_W-1:0]     o_x,
    output logic [sas_pkg::POS_W-1:0]     o_y
);
    import sas_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BITS + 1);

    logic [CNT_W-1:0]      r_cnt;
    logic                  r_mul;
    logic                  r_done;
    logic [FRAME_BITS-1:0] r_quo;
    logic [10:0]           r_rem;
    logic [POS_W-1:0]      r_x;
    logic [POS_W-1:0]      r_y;

    logic [10:0]              cols;
    logic [11:0]              rem_sh;
    logic                     fits;
    logic [23:0]              prod_x;
    logic [FRAME_BITS+12:0]   prod_y;

    assign cols   = (i_geom.cols == 11'd0) ? 11'd1 : i_geom.cols;
    assign rem_sh = {r_rem, r_quo[FRAME_BITS-1]};
    assign fits   = rem_sh >= {1'b0, cols};
    assign prod_x = 24'(r_rem) * 24'(i_geom.width);
    assign prod_y = (FRAME_BITS + 13)'(r_quo) * (FRAME_BITS + 13)'(i_geom.height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_mul  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(FRAME_BITS);
            r_mul  <= 1'b0;
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_mul <= 1'b1;
            end
        end else if (r_mul) begin
            r_mul  <= 1'b0;
            r_done <= 1'b1;
        end else begin
            r_done <= 1'b0;
        end
    end

    // Restoring divide: one quotient bit per cycle, MSB first.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_frame;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[FRAME_BITS-2:0], fits};
            r_rem <= fits ? 11'(rem_sh - {1'b0, cols}) : rem_sh[10:0];
        end
        if (r_cnt == '0 && r_mul) begin
            r_x <= prod_x[POS_W-1:0];
            r_y <= POS_W'(prod_y);
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sprite animation sequencer: directed and random requests.
module testbench;
    import sas_pkg::*;

    localparam int ANIMS        = 16;
    localparam int QDEPTH       = 8;
    localparam int QAW          = $clog2(QDEPTH);
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 210;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd6;

    typedef struct packed {
        logic [9:0]       frame;
        logic [POS_W-1:0] src_x;
        logic [POS_W-1:0] src_y;
        logic             advanced;
        logic [1:0]       status;
    } t_frame_view;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_ready;
    t_mode                 i_mode        = MODE_TICK;
    logic [ID_W-1:0]       i_anim_id     = '0;
    logic [LOOP_W-1:0]     i_loop_count  = '0;
    logic [9:0]            i_first_frame = '0;
    logic [9:0]            i_last_frame  = '0;
    logic                  o_valid;
    logic                  i_ready       = 1'b0;
    logic [9:0]            o_frame_index;
    logic [POS_W-1:0]      o_source_x;
    logic [POS_W-1:0]      o_source_y;
    logic                  o_frame_advanced;
    logic [1:0]            o_status;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [15:0]           i_cfg_data    = '0;

    sprite_animation_sequencer_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_anim_id        (i_anim_id),
        .i_loop_count     (i_loop_count),
        .i_first_frame    (i_first_frame),
        .i_last_frame     (i_last_frame),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_frame_index    (o_frame_index),
        .o_source_x       (o_source_x),
        .o_source_y       (o_source_y),
        .o_frame_advanced (o_frame_advanced),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Predicted sequencer state
    bit [15:0]   period_r;
    bit [10:0]   cols_r;
    bit [12:0]   width_r;
    bit [12:0]   height_r;
    bit [9:0]    anim_lo    [ANIMS];
    bit [9:0]    anim_hi    [ANIMS];
    bit          anim_known [ANIMS];
    bit [3:0]    slot_id    [QDEPTH];
    bit [15:0]   slot_loops [QDEPTH];
    bit [QAW-1:0] q_head;
    int unsigned q_count;
    bit [3:0]    cur_anim;
    bit [9:0]    cur_frame;
    bit [15:0]   tick_count;

    t_frame_view frame_views_due [$];
    int          mismatches  = 0;
    bit          steady_flow = 1'b0;
    bit          valid_up    = 1'b0;

    function automatic void reset_sequencer_model();
        period_r   = 16'd100;
        cols_r     = 11'd1;
        width_r    = 13'd16;
        height_r   = 13'd16;
        anim_lo    = '{default: '0};
        anim_hi    = '{default: '0};
        anim_known = '{default: 1'b0};
        q_head     = '0;
        q_count    = 0;
        cur_anim   = '0;
        cur_frame  = '0;
        tick_count = '0;
    endfunction

    function automatic void enqueue(bit [3:0] id, bit [15:0] loops);
        bit [QAW-1:0] slot;
        slot = QAW'((int'(q_head) + q_count) % QDEPTH);
        slot_id[slot]    = id;
        slot_loops[slot] = loops;
        q_count++;
    endfunction

    function automatic void step_frame();
        bit [10:0] next_frame;
        next_frame = {1'b0, cur_frame} + 11'd1;
        if (next_frame <= {1'b0, anim_hi[cur_anim]}) begin
            cur_frame = next_frame[9:0];
            return;
        end
        // Use up one loop of the head entry; zero loops means endless
        if (q_count > 0) begin
            if (slot_loops[q_head] != 16'd0) begin
                slot_loops[q_head]--;
                if (slot_loops[q_head] == 16'd0) begin
                    q_head = QAW'((int'(q_head) + 1) % QDEPTH);
                    q_count--;
                end
            end
            if (q_count > 0)
                cur_anim = slot_id[q_head];
        end
        cur_frame = anim_lo[cur_anim];
    endfunction

    function automatic t_frame_view apply_request(t_mode mode, bit [3:0] id, bit [15:0] loops,
                                                  bit [9:0] first, bit [9:0] last);
        t_frame_view view;
        int unsigned cols;
        int unsigned pos;
        view.advanced = 1'b0;
        view.status   = STATUS_OK;
        case (mode)
            MODE_TICK: begin
                if (tick_count != 16'hFFFF)
                    tick_count++;
                if (tick_count >= period_r) begin
                    tick_count = '0;
                    step_frame();
                    view.advanced = 1'b1;
                end
            end
            MODE_PLAY: begin
                if (anim_known[id]) begin
                    q_head  = '0;
                    q_count = 0;
                    enqueue(id, loops);
                    cur_anim      = id;
                    cur_frame     = anim_lo[id];
                    tick_count    = '0;
                    view.advanced = 1'b1;
                end else begin
                    view.status = STATUS_UNDEFINED;
                end
            end
            MODE_QUEUE: begin
                if (q_count >= QDEPTH)
                    view.status = STATUS_QUEUE_FULL;
                else
                    enqueue(id, loops);
            end
            default: begin
                anim_lo[id]    = first;
                anim_hi[id]    = last;
                anim_known[id] = 1'b1;
            end
        endcase
        cols       = (cols_r == 11'd0) ? 1 : int'(cols_r);
        view.frame = cur_frame;
        pos        = (int'(cur_frame) % cols) * int'(width_r);
        view.src_x = pos[POS_W-1:0];
        pos        = (int'(cur_frame) / cols) * int'(height_r);
        view.src_y = pos[POS_W-1:0];
        return view;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Receiver side: stall at random unless in a steady stretch
    always @(posedge i_clk) begin
        if (steady_flow)
            i_ready <= 1'b1;
        else
            i_ready <= ($urandom_range(0, 99) >= 34);
    end

    always @(posedge i_clk) begin
        t_frame_view want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (frame_views_due.size() == 0) begin
                flag_mismatch("unexpected result frame_index", 32'(o_frame_index), 32'd0);
            end else begin
                want = frame_views_due.pop_front();
                if (o_frame_index !== want.frame)
                    flag_mismatch("frame_index", 32'(o_frame_index), 32'(want.frame));
                if (o_source_x !== want.src_x)
                    flag_mismatch("source_x", 32'(o_source_x), 32'(want.src_x));
                if (o_source_y !== want.src_y)
                    flag_mismatch("source_y", 32'(o_source_y), 32'(want.src_y));
                if (o_frame_advanced !== want.advanced)
                    flag_mismatch("frame_advanced", 32'(o_frame_advanced), 32'(want.advanced));
                if (o_status !== want.status)
                    flag_mismatch("status", 32'(o_status), 32'(want.status));
            end
        end
    end

    task automatic lower_valid();
        if (valid_up) begin
            i_valid  <= 1'b0;
            valid_up  = 1'b0;
        end
    endtask

    task automatic send_request(t_mode mode, bit [3:0] id, bit [15:0] loops,
                                bit [9:0] first, bit [9:0] last);
        if (!steady_flow && $urandom_range(0, 99) < 34) begin
            lower_valid();
            repeat ($urandom_range(1, 32)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        valid_up       = 1'b1;
        i_mode        <= mode;
        i_anim_id     <= id;
        i_loop_count  <= loops;
        i_first_frame <= first;
        i_last_frame  <= last;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        frame_views_due.push_back(apply_request(mode, id, loops, first, last));
    endtask

    // Drop valid and wait until every request has its result back
    task automatic settle();
        lower_valid();
        while (frame_views_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_FRAME_PERIOD:  period_r = data;
            CFG_SHEET_COLUMNS: cols_r   = data[10:0];
            CFG_FRAME_WIDTH:   width_r  = data[12:0];
            CFG_FRAME_HEIGHT:  height_r = data[12:0];
            default: ;
        endcase
    endtask

    // Program all registers, plus one write to an unmapped index that must be dropped
    task automatic configure(bit [15:0] period, bit [15:0] cols, bit [15:0] width,
                             bit [15:0] height);
        settle();
        write_reg(CFG_FRAME_PERIOD, period);
        write_reg(CFG_SHEET_COLUMNS, cols);
        write_reg(CFG_FRAME_WIDTH, width);
        write_reg(CFG_FRAME_HEIGHT, height);
        write_reg(CFG_UNMAPPED, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic bit [15:0] draw_loops();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 3));
    endfunction

    task automatic test_reset_defaults();
        send_request(MODE_TICK, 4'd0, 16'd0, 10'd0, 10'd0);
        send_request(MODE_PLAY, 4'd7, 16'd1, 10'd0, 10'd0);
    endtask

    task automatic test_playback_sequence();
        configure(16'd1, 16'd4, 16'd16, 16'd8);
        send_request(MODE_DEFINE, 4'd0, 16'd0, 10'd0, 10'd1);
        send_request(MODE_DEFINE, 4'd1, 16'd0, 10'd5, 10'd6);
        // first frame above last frame: restart on every step
        send_request(MODE_DEFINE, 4'd2, 16'd0, 10'd9, 10'd3);
        send_request(MODE_DEFINE, 4'd15, 16'd0, 10'd1022, 10'd1023);
        send_request(MODE_PLAY, 4'd0, 16'd2, 10'd0, 10'd0);
        send_request(MODE_QUEUE, 4'd1, 16'd1, 10'd0, 10'd0);
        send_request(MODE_QUEUE, 4'd2, 16'd0, 10'd0, 10'd0);
        // loop twice, hand over to anim 1, then to the endless anim 2
        repeat (7) send_request(MODE_TICK, 4'd0, 16'd0, 10'd0, 10'd0);
    endtask

    task automatic test_queue_overflow();
        send_request(MODE_PLAY, 4'd15, 16'hFFFF, 10'd0, 10'd0);
        repeat (7) send_request(MODE_QUEUE, 4'($urandom), 16'($urandom), 10'($urandom),
                                10'($urandom));
        send_request(MODE_QUEUE, 4'd3, 16'd5, 10'd0, 10'd0);
        // step to the top frame index, then wrap past it
        repeat (2) send_request(MODE_TICK, 4'd0, 16'd0, 10'd0, 10'd0);
    endtask

    task automatic test_geometry_extremes();
        // zero period and zero columns, widest frames so the position overflows
        configure(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
        send_request(MODE_PLAY, 4'd15, 16'd3, 10'd0, 10'd0);
        repeat (2) send_request(MODE_TICK, 4'd0, 16'd0, 10'd0, 10'd0);
        configure(16'hFFFF, 16'h07FF, 16'hFFFF, 16'd1);
        repeat (2) send_request(MODE_TICK, 4'hF, 16'hFFFF, 10'h3FF, 10'h3FF);
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          sent;
        int          roll;
        int          burst;
        int unsigned lo;
        int unsigned hi;
        bit [15:0]   cols;
        for (phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 3))
                0:       cols = 16'd1;
                1:       cols = 16'($urandom_range(2, 8));
                2:       cols = 16'd1024;
                default: cols = 16'($urandom);
            endcase
            configure(($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 4))
                                                  : 16'($urandom_range(5, 60)),
                      cols,
                      ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 64)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 64)));
            steady_flow = (phase == 2);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 10) begin
                    send_request(t_mode'($urandom_range(0, 3)), 4'($urandom), 16'($urandom),
                                 10'($urandom), 10'($urandom));
                    sent++;
                end else if (roll < 22) begin
                    lo = $urandom_range(0, 1023);
                    if ($urandom_range(0, 9) == 0)
                        hi = $urandom_range(0, 1023);
                    else
                        hi = lo + $urandom_range(0, 4);
                    if (hi > 1023)
                        hi = 1023;
                    send_request(MODE_DEFINE, 4'($urandom), 16'($urandom), 10'(lo), 10'(hi));
                    sent++;
                end else if (roll < 34) begin
                    send_request(MODE_PLAY, 4'($urandom), draw_loops(), 10'($urandom),
                                 10'($urandom));
                    sent++;
                end else if (roll < 50) begin
                    send_request(MODE_QUEUE, 4'($urandom), draw_loops(), 10'($urandom),
                                 10'($urandom));
                    sent++;
                end else begin
                    burst = $urandom_range(1, 8);
                    repeat (burst)
                        send_request(MODE_TICK, 4'($urandom), 16'($urandom), 10'($urandom),
                                     10'($urandom));
                    sent += burst;
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        reset_sequencer_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_playback_sequence();
        test_queue_overflow();
        test_geometry_extremes();
        test_random_traffic();
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && frame_views_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", frame_views_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sas_pkg.sv
rtl/sas_anim_tbl.sv
rtl/sas_queue_ram.sv
rtl/sas_pos_unit.sv
rtl/sprite_animation_sequencer_unit.sv
verif/testbench.sv
